FILE: rtl/mpf_pkg.sv
package mpf_pkg;

  // default store depth and minimum capture count
  localparam int unsigned MAX_PERIODS_DEF  = 16;
  localparam int unsigned MIN_CAPTURES_DEF = 6;

  // counter clock after reset
  localparam logic [31:0] CLOCK_RATE_RESET = 32'd80000000;

  // field widths
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

endpackage

FILE: rtl/median_period_frequency_top.sv
// Median-period frequency estimator.
// Input stream (s_*): one comparator rising-edge timestamp per transaction,
// s_tlast on the final capture of a listening window. Each capture after the
// first gives a period (modulo 2^32 difference); the first MAX_PERIODS
// periods go into a sorted store, later captures are only counted.
// Output stream (m_*): one transaction per window, after the tlast capture:
// m_tdata is the rounded clock_rate_hz / median period, m_tuser the status
// (ok, too few captures, zero median); on failure m_tdata is zero.
// Configuration: cfg_we writes cfg_wdata into clock_rate_hz; write only idle.
// Sequence: an insert costs a store read, one compare per entry examined and
// a write, and no new capture is taken until it is done; the store is
// single-write, single-read. The final capture then adds the median read,
// the bit-serial divider (one quotient bit a cycle) and the output register;
// too few captures skip both, a zero median skips the divider.
// s_tready is high only while no capture is in progress.
// The result sits in an output register: a stalled receiver holds it, and
// new captures are still taken; a second result waits until it is drained.
// Reset clears the window (previous stamp and count) and the output valid
// and sets clock_rate_hz to 80 MHz; the store needs no clearing.
module median_period_frequency_top #(
  parameter int unsigned MAX_PERIODS  = mpf_pkg::MAX_PERIODS_DEF,
  parameter int unsigned MIN_CAPTURES = mpf_pkg::MIN_CAPTURES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mpf_pkg::STAMP_W-1:0]   s_tdata,   // [31:0] timestamp
  input  logic                          s_tlast,   // last_capture
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mpf_pkg::FREQ_W-1:0]    m_tdata,   // [31:0] freq_hz
  output logic [mpf_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);
  import mpf_pkg::*;

  localparam int unsigned CAPTURE_SAT =
    ((MAX_PERIODS + 1) > MIN_CAPTURES) ? (MAX_PERIODS + 1) : MIN_CAPTURES;
  localparam int unsigned CW  = $clog2(CAPTURE_SAT + 1);
  localparam int unsigned LW  = $clog2(MAX_PERIODS + 1);
  localparam int unsigned AW  = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int unsigned DVW = STAMP_W + 1;
  localparam int unsigned DCW = $clog2(DVW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_PUT, ST_MRD, ST_MCHK, ST_DIV, ST_OUT
  } state_t;

  state_t              state;
  logic [31:0]         clock_rate_hz;
  logic [STAMP_W-1:0]  prev_stamp;
  logic [CW-1:0]       count;
  logic [STAMP_W-1:0]  value;
  logic [AW-1:0]       j;
  logic                last_pend;
  logic                few_pend;
  logic [AW-1:0]       med_addr;
  logic [STAMP_W-1:0]  divisor;
  logic [DVW-1:0]      dividend;
  logic [STAMP_W-1:0]  rem;
  logic [FREQ_W-1:0]   quot;
  logic [DCW-1:0]      div_cnt;
  logic [FREQ_W-1:0]   res_freq;
  status_t             res_status;

  // period store
  logic [STAMP_W-1:0]  mem [MAX_PERIODS];
  logic [STAMP_W-1:0]  rdata;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [STAMP_W-1:0]  wdata;

  logic                accept;
  logic [CW-1:0]       count_m1;
  logic [LW-1:0]       len;
  logic [CW-1:0]       count_new;
  logic [CW-1:0]       count_new_m1;
  logic [LW-1:0]       stored_new;
  logic                few_new;
  logic                do_insert;
  state_t              after_ins;
  logic                last_ins_step;
  logic [DVW-1:0]      trial;
  logic                qbit;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // stored length before and after this capture
  always_comb begin
    count_m1 = count - CW'(1);
    if (count == '0) begin
      len = '0;
    end else if (count_m1 < CW'(MAX_PERIODS)) begin
      len = count_m1[LW-1:0];
    end else begin
      len = LW'(MAX_PERIODS);
    end
    count_new    = (count < CW'(CAPTURE_SAT)) ? count + CW'(1) : count;
    count_new_m1 = count_new - CW'(1);
    stored_new   = (count_new_m1 < CW'(MAX_PERIODS)) ? count_new_m1[LW-1:0]
                                                      : LW'(MAX_PERIODS);
    few_new      = (count_new < CW'(MIN_CAPTURES)) || (stored_new == '0);
    do_insert    = (count != '0) && (len < LW'(MAX_PERIODS));
  end

  // where to go once the capture is filed
  always_comb begin
    if (!last_pend) begin
      after_ins = ST_IDLE;
    end else if (few_pend) begin
      after_ins = ST_OUT;
    end else begin
      after_ins = ST_MRD;
    end
  end

  assign last_ins_step = (j == AW'(1));

  // store port control
  always_comb begin
    raddr = j - AW'(1);
    we    = 1'b0;
    waddr = j;
    wdata = value;
    unique case (state)
      ST_RD:   raddr = j - AW'(1);
      ST_CMP: begin
        raddr = j - AW'(2);
        if (rdata > value) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      ST_PUT:  we = 1'b1;
      ST_MRD:  raddr = med_addr;
      default: raddr = j - AW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // restoring divider step
  assign trial = {rem, dividend[DVW-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  // control, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      clock_rate_hz <= CLOCK_RATE_RESET;
      prev_stamp    <= '0;
      count         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        clock_rate_hz <= cfg_wdata;
      end
      // in ST_OUT a drained result is replaced by the new one below
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            value      <= s_tdata - prev_stamp;
            j          <= len[AW-1:0];
            last_pend  <= s_tlast;
            few_pend   <= few_new;
            med_addr   <= AW'(stored_new >> 1);
            res_freq   <= '0;
            res_status <= STATUS_FEW;
            prev_stamp <= s_tlast ? '0 : s_tdata;
            count      <= s_tlast ? '0 : count_new;
            if (do_insert) begin
              state <= (len == '0) ? ST_PUT : ST_RD;
            end else if (!s_tlast) begin
              state <= ST_IDLE;
            end else begin
              state <= few_new ? ST_OUT : ST_MRD;
            end
          end
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          if (rdata > value) begin
            j <= j - AW'(1);
            if (last_ins_step) begin
              state <= ST_PUT;
            end
          end else begin
            state <= ST_PUT;
          end
        end
        ST_PUT: state <= after_ins;
        ST_MRD: state <= ST_MCHK;
        ST_MCHK: begin
          if (rdata == '0) begin
            res_status <= STATUS_ZERO;
            state      <= ST_OUT;
          end else begin
            divisor  <= rdata;
            dividend <= {1'b0, clock_rate_hz} + {2'b0, rdata[STAMP_W-1:1]};
            rem      <= '0;
            quot     <= '0;
            div_cnt  <= DCW'(DVW);
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          dividend <= {dividend[DVW-2:0], 1'b0};
          rem      <= qbit ? STAMP_W'(trial - {1'b0, divisor}) : trial[STAMP_W-1:0];
          quot     <= {quot[FREQ_W-2:0], qbit};
          div_cnt  <= div_cnt - DCW'(1);
          if (div_cnt == DCW'(1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= (res_status == STATUS_OK) ? quot : res_freq;
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_DIV && div_cnt == DCW'(1)) begin
        res_status <= STATUS_OK;
      end
    end
  end

  // checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
    else $error("failed result carries a non-zero frequency");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPTURE_SAT))
    else $error("capture count beyond saturation");

  a_window_close: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> (count == '0) && (prev_stamp == '0))
    else $error("window not closed after final capture");

  a_cmp_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> ($past(state) == ST_RD) || ($past(state) == ST_CMP))
    else $error("compare step without a store read");

endmodule
